>>> hw/rtl/rbs_pkg.sv
// Shared types and constants for the ray/box slab test block.
`timescale 1ns / 1ps
`default_nettype none
package rbs_pkg;
   localparam int COORD_W = 32;
   localparam int AXES    = 3;
   localparam int REQ_W   = 12 * COORD_W;
   localparam int RSP_W   = 8;

   // Per-axis flags that run beside the dividers
   typedef struct packed {
      logic zero_dir;   // direction component is zero
      logic outside;    // origin outside the slab (used when zero_dir)
   } axis_flags_type;
endpackage
`default_nettype wire

>>> hw/rtl/rbs_div.sv
// Pipelined restoring divider, one quotient bit per stage, signed saturated result.
`timescale 1ns / 1ps
`default_nettype none
module rbs_div import rbs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [COORD_W+FRAC_BITS-1:0] num,   // |dividend| scaled
   input  wire logic [COORD_W-1:0]           den,   // |divisor|
   input  wire logic                         neg,   // result sign
   output logic signed [COORD_W+FRAC_BITS:0] quot
);
   localparam int NW = COORD_W + FRAC_BITS;
   localparam int TW = NW + 1;
   localparam logic [NW-1:0] NEG_LIM = NW'(1) << (NW-1);
   localparam logic [NW-1:0] TMAX    = NEG_LIM - NW'(1);

   logic [NW-1:0]      num_ff [0:NW];
   logic [COORD_W-1:0] rem_ff [0:NW];
   logic [COORD_W-1:0] den_ff [0:NW];
   logic               neg_ff [0:NW];
   logic signed [TW-1:0] quot_ff;

   // Load stage
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= num;
         rem_ff[0] <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
      end
   end

   // One compare-subtract per stage
   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [COORD_W:0] shifted;
      logic             take;
      assign shifted = {rem_ff[k], num_ff[k][NW-1]};
      assign take    = shifted >= {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= take ? COORD_W'(shifted - {1'b0, den_ff[k]})
                                : shifted[COORD_W-1:0];
            num_ff[k+1] <= {num_ff[k][NW-2:0], take};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   // Apply sign and saturate to the signed t range
   logic signed [TW-1:0] quot_in;
   always_comb begin
      if (neg_ff[NW]) begin
         if (num_ff[NW] > NEG_LIM) quot_in = -$signed({1'b0, NEG_LIM});
         else                      quot_in = -$signed({1'b0, num_ff[NW]});
      end else begin
         if (num_ff[NW] > TMAX)    quot_in = $signed({1'b0, TMAX});
         else                      quot_in = $signed({1'b0, num_ff[NW]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;
endmodule
`default_nettype wire

>>> hw/rtl/rbs_lane.sv
// One axis lane: bound selection, two slab dividers and the delayed axis flags.
`timescale 1ns / 1ps
`default_nettype none
module rbs_lane import rbs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic signed [COORD_W-1:0]    origin,
   input  wire logic signed [COORD_W-1:0]    dir,
   input  wire logic signed [COORD_W-1:0]    box_min,
   input  wire logic signed [COORD_W-1:0]    box_max,
   output logic signed [COORD_W+FRAC_BITS:0] near_t,
   output logic signed [COORD_W+FRAC_BITS:0] far_t,
   output axis_flags_type                    flags
);
   localparam int NW  = COORD_W + FRAC_BITS;
   localparam int LAT = NW + 2;

   logic signed [COORD_W:0] diff_min, diff_max, near_d, far_d;
   logic [COORD_W-1:0]      near_mag, far_mag, dir_mag;
   logic                    dir_neg;
   axis_flags_type          flags_in;
   axis_flags_type          flags_ff [0:LAT-1];

   // Differences and bound choice by direction sign
   always_comb begin
      diff_min = (COORD_W+1)'(box_min) - (COORD_W+1)'(origin);
      diff_max = (COORD_W+1)'(box_max) - (COORD_W+1)'(origin);
      dir_neg  = dir[COORD_W-1];
      near_d   = dir_neg ? diff_max : diff_min;
      far_d    = dir_neg ? diff_min : diff_max;
      near_mag = COORD_W'(near_d[COORD_W] ? -near_d : near_d);
      far_mag  = COORD_W'(far_d[COORD_W] ? -far_d : far_d);
      dir_mag  = dir_neg ? COORD_W'(-dir) : COORD_W'(dir);
      flags_in.zero_dir = (dir == '0);
      flags_in.outside  = (origin < box_min) || (origin > box_max);
   end

   rbs_div #(.FRAC_BITS(FRAC_BITS)) u_near (
      .clock(clock), .en(en),
      .num({near_mag, {FRAC_BITS{1'b0}}}), .den(dir_mag),
      .neg(near_d[COORD_W] ^ dir_neg), .quot(near_t)
   );

   rbs_div #(.FRAC_BITS(FRAC_BITS)) u_far (
      .clock(clock), .en(en),
      .num({far_mag, {FRAC_BITS{1'b0}}}), .den(dir_mag),
      .neg(far_d[COORD_W] ^ dir_neg), .quot(far_t)
   );

   // Flags follow the divider latency
   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff[0] <= flags_in;
         for (int i = 1; i < LAT; i++) flags_ff[i] <= flags_ff[i-1];
      end
   end

   assign flags = flags_ff[LAT-1];
endmodule
`default_nettype wire

>>> hw/rtl/rbs_merge.sv
// Merges the three axis intervals into the hit decision.
`timescale 1ns / 1ps
`default_nettype none
module rbs_merge import rbs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic signed [COORD_W+FRAC_BITS:0] near_t [0:AXES-1],
   input  wire logic signed [COORD_W+FRAC_BITS:0] far_t  [0:AXES-1],
   input  wire axis_flags_type                    flags  [0:AXES-1],
   output logic                                   hit
);
   localparam int TW = COORD_W + FRAC_BITS + 1;

   logic signed [TW-1:0] lo, hi;
   logic                 lo_set, hi_set, miss;

   // Narrow the running interval axis by axis
   always_comb begin
      lo = '0; hi = '0; lo_set = 1'b0; hi_set = 1'b0; miss = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         if (!miss) begin
            if (flags[a].zero_dir) begin
               if (flags[a].outside) miss = 1'b1;
            end else if ((lo_set && lo > far_t[a]) || (hi_set && near_t[a] > hi)) begin
               miss = 1'b1;
            end else begin
               if (!lo_set || near_t[a] > lo) lo = near_t[a];
               if (!hi_set || far_t[a] < hi)  hi = far_t[a];
               lo_set = 1'b1;
               hi_set = 1'b1;
            end
         end
      end
      hit = !miss;
   end
endmodule
`default_nettype wire

>>> hw/rtl/ray_box_slab_test.sv
// Ray versus axis-aligned box slab test, top level.
// Usage:
//   req channel: one item per ray/box pair, twelve signed Q16.16 fields.
//   rsp channel: one item per request, tdata[0] = hit.
//   Items are taken every cycle while not stalled; each axis has its own
//   lane with two pipelined restoring dividers (one quotient bit per
//   stage), and a merge stage combines the three intervals.
//   Path from accept to rsp_tvalid: load stage, 32 + FRAC_BITS divider
//   stages, saturation stage, merge into the output register.
//   Throughput: one item per cycle while no output stall holds the pipeline.
//   Stall: when rsp_tready is low with a result held, the whole pipeline
//   freezes and req_tready drops; no item is lost or repeated.
//   Reset: synchronous; clears all valid bits, pipeline empties.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test import rbs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // hit, then zero padding
   output logic [RSP_W-1:0]      rsp_tdata
);
   localparam int TW  = COORD_W + FRAC_BITS + 1;
   localparam int LAT = COORD_W + FRAC_BITS + 2;

   logic                 en;
   logic [LAT-1:0]       vld_ff, vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 hit_ff, hit_in;
   logic signed [TW-1:0] near_t [0:AXES-1];
   logic signed [TW-1:0] far_t  [0:AXES-1];
   axis_flags_type       flags  [0:AXES-1];

   // Pipeline advances whenever the output slot is free or being taken
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en && !reset;

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .en(en),
         .origin ($signed(req_tdata[(0+a)*COORD_W +: COORD_W])),
         .dir    ($signed(req_tdata[(3+a)*COORD_W +: COORD_W])),
         .box_min($signed(req_tdata[(6+a)*COORD_W +: COORD_W])),
         .box_max($signed(req_tdata[(9+a)*COORD_W +: COORD_W])),
         .near_t(near_t[a]), .far_t(far_t[a]), .flags(flags[a])
      );
   end

   rbs_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .near_t(near_t), .far_t(far_t), .flags(flags), .hit(hit_in)
   );

   // Valid tracking and output register
   always_comb begin
      vld_in       = {vld_ff[LAT-2:0], req_tvalid};
      rsp_valid_in = vld_ff[LAT-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-1){1'b0}}, hit_ff};
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the ray/box slab test block: directed table plus random rays.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import rbs_pkg::*;

   localparam int FRAC   = 16;
   localparam int LAT    = 32 + FRAC + 3;
   localparam int N_RAND = 1300;
   localparam int WDOG   = 20000;

   typedef struct {
      logic signed [31:0] org [3];
      logic signed [31:0] dir [3];
      logic signed [31:0] bmin [3];
      logic signed [31:0] bmax [3];
   } ray_box_type;

   typedef struct {
      ray_box_type rb;
      int          hit_known;   // -1: use the slab predictor
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   logic             hits_due [$];
   int               n_fail = 0;
   int               n_sent = 0;
   int               n_hits = 0;
   int               n_miss = 0;
   int               idle_cycles = 0;
   bit               long_hold = 1'b0;
   bit               hold_done = 1'b0;

   ray_box_slab_test #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // (bound - origin) * 2^FRAC / dir, truncated, saturated to Q32.FRAC
   function automatic longint slab_t(longint diff, longint d);
      longint tmax;
      longint q;
      tmax = (longint'(1) <<< (31 + FRAC)) - 1;
      q = (diff * (longint'(1) <<< FRAC)) / d;
      if (q > tmax) return tmax;
      if (q < -tmax - 1) return -tmax - 1;
      return q;
   endfunction

   function automatic logic ray_meets_box(ray_box_type rb);
      longint lo, hi, o, d, mn, mx, t_near, t_far;
      lo = -(longint'(1) <<< 62);
      hi = longint'(1) <<< 62;
      for (int a = 0; a < 3; a++) begin
         o = rb.org[a]; d = rb.dir[a]; mn = rb.bmin[a]; mx = rb.bmax[a];
         if (d == 0) begin
            if (o < mn || o > mx) return 1'b0;
            continue;
         end
         if (d > 0) begin
            t_near = slab_t(mn - o, d); t_far = slab_t(mx - o, d);
         end else begin
            t_near = slab_t(mx - o, d); t_far = slab_t(mn - o, d);
         end
         if (lo > t_far || t_near > hi) return 1'b0;
         if (t_near > lo) lo = t_near;
         if (t_far < hi) hi = t_far;
      end
      return 1'b1;
   endfunction

   function automatic logic [REQ_W-1:0] pack_item(ray_box_type rb);
      logic [REQ_W-1:0] v;
      for (int a = 0; a < 3; a++) begin
         v[a*32 +: 32]      = rb.org[a];
         v[(3+a)*32 +: 32]  = rb.dir[a];
         v[(6+a)*32 +: 32]  = rb.bmin[a];
         v[(9+a)*32 +: 32]  = rb.bmax[a];
      end
      return v;
   endfunction

   function automatic logic signed [31:0] q16(int whole);
      return whole <<< 16;
   endfunction

   // unit box [-1,1]^3, ray from (ox,oy,oz) along (dx,dy,dz), whole units
   function automatic ray_box_type unit_case(int ox, int oy, int oz,
                                             int dx, int dy, int dz);
      ray_box_type rb;
      int o [3];
      int d [3];
      o = '{ox, oy, oz}; d = '{dx, dy, dz};
      for (int a = 0; a < 3; a++) begin
         rb.org[a] = q16(o[a]); rb.dir[a] = q16(d[a]);
         rb.bmin[a] = q16(-1); rb.bmax[a] = q16(1);
      end
      return rb;
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return q16($urandom_range(0, 40)) - q16(20);
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         3: return 0;
         4: return $signed($urandom_range(0, 2000)) - 1000;
         default: return q16($urandom_range(0, 8)) - q16(4) + $urandom_range(0, 65535);
      endcase
   endfunction

   // mostly ordered boxes, some raw noise
   function automatic ray_box_type rand_item();
      ray_box_type rb;
      logic signed [31:0] p, q;
      for (int a = 0; a < 3; a++) begin
         rb.org[a] = rand_coord();
         rb.dir[a] = ($urandom_range(0, 7) == 0) ? 0 : rand_coord();
         p = rand_coord(); q = rand_coord();
         if ($urandom_range(0, 9) != 0 && p > q) begin
            rb.bmin[a] = q; rb.bmax[a] = p;
         end else begin
            rb.bmin[a] = p; rb.bmax[a] = q;
         end
      end
      return rb;
   endfunction

   task automatic send_item(ray_box_type rb);
      req_tdata  <= pack_item(rb);
      req_tvalid <= 1'b1;
      hits_due.push_back(ray_meets_box(rb));
      do @(posedge clock); while (!req_tready);
      n_sent++;
   endtask

   task automatic send_gap();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   // result check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hits_due.size() == 0) begin
            $error("unexpected result: hit exp none act %0d", rsp_tdata[0]);
            n_fail++;
         end else begin
            logic h;
            h = hits_due.pop_front();
            if (rsp_tdata[0] !== h) begin
               $error("field hit: exp %0d act %0d", h, rsp_tdata[0]);
               n_fail++;
            end
            if (h) n_hits++; else n_miss++;
         end
      end
   end

   // receiver stall pattern, plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (long_hold) rsp_tready <= 1'b0;
      else case ($urandom_range(0, 3))
         0: rsp_tready <= (n_sent % 200) < 100;
         1: rsp_tready <= $urandom_range(0, 2) != 0;
         default: rsp_tready <= 1'b1;
      endcase
   end

   initial begin
      wait (n_sent >= 400);
      long_hold = 1'b1;
      repeat (300) @(posedge clock);
      long_hold = 1'b0;
      hold_done = 1'b1;
   end

   // watchdog: cycles without any accepted request or taken result
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      row_type rows [$];
      ray_box_type rb;
      int burst;
      // through the center, behind, beside, parallel in/out, inverted, extremes
      rows.push_back(row_type'{unit_case(-5, 0, 0, 1, 0, 0), 1});
      rows.push_back(row_type'{unit_case(5, 0, 0, 1, 0, 0), 1});
      rows.push_back(row_type'{unit_case(-5, 3, 0, 1, 0, 0), 0});
      rows.push_back(row_type'{unit_case(0, 0, 0, 0, 0, 0), 1});
      rows.push_back(row_type'{unit_case(2, 0, 0, 0, 1, 1), 0});
      rows.push_back(row_type'{unit_case(1, 1, 1, 0, 0, 0), 1});
      rows.push_back(row_type'{unit_case(-5, -5, -5, 1, 1, 1), 1});
      rows.push_back(row_type'{unit_case(-5, 5, 0, 1, -1, 0), -1});
      rows.push_back(row_type'{unit_case(-5, 0, 5, 1, 0, -1), -1});
      rows.push_back(row_type'{unit_case(-5, 2, 0, 1, 1, 0), -1});
      rb = unit_case(0, 0, 0, 0, 0, 0);
      rb.bmin[1] = q16(1); rb.bmax[1] = q16(-1);
      rows.push_back(row_type'{rb, 0});
      rb = unit_case(-5, 0, 0, 1, 0, 0);
      rb.bmin[0] = q16(1); rb.bmax[0] = q16(-1);
      rows.push_back(row_type'{rb, -1});
      for (int k = 0; k < 6; k++) begin
         logic signed [31:0] e;
         e = k[0] ? 32'sh7fffffff : 32'sh80000000;
         for (int a = 0; a < 3; a++) begin
            rb.org[a]  = (k < 2) ? e : -e - 1;
            rb.dir[a]  = (k == 4) ? 32'sh1 : ((k == 5) ? 32'sh80000000 : e);
            rb.bmin[a] = 32'sh80000000;
            rb.bmax[a] = 32'sh7fffffff;
         end
         rows.push_back(row_type'{rb, -1});
      end
      rb = unit_case(0, 0, 0, 0, 0, 0);
      for (int a = 0; a < 3; a++) begin
         rb.org[a] = -1; rb.dir[a] = 32'sh1; rb.bmin[a] = 0; rb.bmax[a] = -2;
      end
      rows.push_back(row_type'{rb, -1});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].hit_known >= 0 &&
             ray_meets_box(rows[i].rb) !== rows[i].hit_known[0]) begin
            $error("table row %0d: hit exp %0d act %0d", i,
                   rows[i].hit_known, ray_meets_box(rows[i].rb));
            n_fail++;
         end
         send_item(rows[i].rb);
      end
      send_gap();

      // random bursts; keep offering through the long hold
      while (n_sent < rows.size() + N_RAND || !hold_done) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst; b++) send_item(rand_item());
         if ($urandom_range(0, 2) == 0) send_gap();
      end
      req_tvalid <= 1'b0;

      wait (hits_due.size() == 0);
      repeat (LAT + 10) @(posedge clock);
      $display("covered %0d items: %0d hits, %0d misses, one long output stall",
               n_sent, n_hits, n_miss);
      if (n_fail == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
